// ----- hdl/lne_pkg.sv -----
// Shared types and constants for the line editor with echo.
package lne_pkg;

  localparam int LINE_LEN_DEF = 32;

  localparam logic [6:0] CH_BS    = 7'd8;
  localparam logic [6:0] CH_TAB   = 7'd9;
  localparam logic [6:0] CH_LF    = 7'd10;
  localparam logic [6:0] CH_CR    = 7'd13;
  localparam logic [6:0] CH_KILL  = 7'd21;
  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_AT    = 7'd64;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_RD_REQ,
    ST_RD_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BS,
    OP_CR,
    OP_STORE,
    OP_KILL
  } op_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       kind;
    logic       last;
  } result_t;

endpackage

// ----- hdl/lne_in_if.sv -----
// Input channel: one received byte per transaction.
interface lne_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source(output valid, output char_in, input ready);
  modport sink(input valid, input char_in, output ready);
endinterface

// ----- hdl/lne_out_if.sv -----
// Output channel: one echo or line character per transaction.
interface lne_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       kind;
  logic       last;

  modport source(output valid, output out_char, output kind, output last, input ready);
  modport sink(input valid, input out_char, input kind, input last, output ready);
endinterface

// ----- hdl/line_editor_with_echo.sv -----
// Top level of the line editor with echo: decode, sequencer and line count.
//
//   channel  dir  payload                      transaction
//   in_ch    in   char_in[7:0]                 valid && ready
//   out_ch   out  out_char[6:0], kind, last    valid && ready
//
// An input byte is taken when the sequencer is idle; each echo character is then
// emitted from the echo buffer, each line character by a memory read and an emit,
// so a carriage return with a non-empty line reads out the line after its echo.
// The output register stalls the sequencer while it is full and ready is low.
// rst is synchronous; it clears the line count and the sequencer. The store
// needs no clearing: only entries below the line count are read.
module line_editor_with_echo #(
  parameter int LINE_LEN = lne_pkg::LINE_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lne_in_if.sink    in_ch,
  lne_out_if.source out_ch
);

  import lne_pkg::*;

  localparam int CW = $clog2(LINE_LEN);
  localparam int AW = $clog2(LINE_LEN - 1);
  localparam logic [CW-1:0] FULL = CW'(LINE_LEN - 1);

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [6:0]    echo_buf [3];
  logic [1:0]    echo_idx;
  logic [1:0]    echo_end;
  logic          then_read;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] rd_len;

  logic       accept;
  logic [6:0] c;
  op_t        op;
  logic       free;
  logic       push;
  result_t    res;
  logic       mem_re;
  logic [6:0] mem_rdata;
  logic       echo_done;
  logic       rd_done;

  assign accept    = in_ch.valid && in_ch.ready;
  assign c         = in_ch.char_in[6:0];
  assign echo_done = (echo_idx == echo_end);
  assign rd_done   = (rd_idx == rd_len - CW'(1));

  always_comb begin
    case (c)
      CH_SPACE, CH_LF, CH_TAB: op = OP_NONE;
      CH_BS:                   op = (count != '0) ? OP_BS : OP_NONE;
      CH_CR:                   op = OP_CR;
      default: begin
        if (c != CH_KILL && count < FULL) begin
          op = OP_STORE;
        end else begin
          op = (count != '0) ? OP_KILL : OP_NONE;
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op != OP_NONE) begin
          state_next = ST_ECHO;
        end
      end
      ST_ECHO: begin
        if (free && echo_done) begin
          state_next = then_read ? ST_RD_REQ : ST_IDLE;
        end
      end
      ST_RD_REQ: state_next = ST_RD_EMIT;
      ST_RD_EMIT: begin
        if (free) begin
          state_next = rd_done ? ST_IDLE : ST_RD_REQ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    push        = 1'b0;
    mem_re      = 1'b0;
    res         = '{out_char: echo_buf[echo_idx], kind: KIND_ECHO,
                    last: echo_done && !then_read};
    case (state)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_ECHO:   push = free;
      ST_RD_REQ: mem_re = 1'b1;
      ST_RD_EMIT: begin
        push = free;
        res  = '{out_char: mem_rdata, kind: KIND_LINE, last: rd_done};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (op)
          OP_BS:    count <= count - CW'(1);
          OP_CR:    count <= '0;
          OP_STORE: count <= count + CW'(1);
          OP_KILL:  count <= '0;
          default:  ;
        endcase
      end
    end
  end

  // load the echo run and readout bounds on each accepted byte, else step the indices
  always_ff @(posedge clk) begin
    if (accept) begin
      echo_idx  <= '0;
      then_read <= 1'b0;
      rd_idx    <= '0;
      rd_len    <= count;
      case (op)
        OP_BS: begin
          echo_buf[0] <= CH_BS;
          echo_buf[1] <= CH_SPACE;
          echo_buf[2] <= CH_BS;
          echo_end    <= 2'd2;
        end
        OP_CR: begin
          echo_buf[0] <= CH_CR;
          echo_buf[1] <= CH_LF;
          echo_end    <= 2'd1;
          then_read   <= (count != '0);
        end
        OP_STORE: begin
          echo_buf[0] <= c;
          echo_end    <= 2'd0;
        end
        OP_KILL: begin
          echo_buf[0] <= CH_AT;
          echo_buf[1] <= CH_CR;
          echo_buf[2] <= CH_LF;
          echo_end    <= 2'd2;
        end
        default: ;
      endcase
    end else begin
      if (state == ST_ECHO && free) begin
        echo_idx <= echo_idx + 2'd1;
      end
      if (state == ST_RD_EMIT && free) begin
        rd_idx <= rd_idx + CW'(1);
      end
    end
  end

  lne_store #(
    .DEPTH (LINE_LEN - 1),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (accept && op == OP_STORE),
    .waddr (count[AW-1:0]),
    .wdata (c),
    .re    (mem_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

  lne_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (res),
    .free   (free),
    .out_ch (out_ch)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("line count beyond store size");

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> state == ST_RD_EMIT)
    else $error("store read not followed by emit");

  a_store_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_STORE) |=> count == $past(count) + CW'(1))
    else $error("stored character not counted");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (push && res.last) |=> state == ST_IDLE)
    else $error("sequencer busy after final result");

endmodule

// ----- hdl/lne_store.sv -----
// Line store: synchronous memory, one write and one registered read port.
module lne_store #(
  parameter int DEPTH = lne_pkg::LINE_LEN_DEF - 1,
  parameter int AW    = $clog2(lne_pkg::LINE_LEN_DEF - 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    rdata
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/lne_out_reg.sv -----
// Output register: holds one result until the sink takes it.
module lne_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lne_pkg::result_t din,
  output logic             free,
  lne_out_if.source        out_ch
);

  import lne_pkg::*;

  logic    valid;
  result_t data;

  assign free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= din;
    end
  end

  assign out_ch.valid    = valid;
  assign out_ch.out_char = data.out_char;
  assign out_ch.kind     = data.kind;
  assign out_ch.last     = data.last;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the line editor with echo: byte stimulus, predicted echo and line readout.
module tb;
  import lne_pkg::*;

  localparam int LINE_LEN = 32;
  localparam int RANDOM_ITEMS = 200;
  localparam int STEADY_FROM = 170;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Tracks the edited line and queues the echo and readout characters it implies.
  class echo_line_tracker;
    int capacity;
    logic [6:0] line_chars[$];
    result_t pending_chars[$];
    int errors;
    int checked;
    int lines_read;
    int kills;
    int full_kills;

    function new(int cap);
      capacity = cap;
    endfunction

    function void push(logic [6:0] ch, logic kind);
      result_t r;
      r.out_char = ch;
      r.kind = kind;
      r.last = 1'b0;
      pending_chars.push_back(r);
    endfunction

    function void kill_line();
      line_chars.delete();
      push(CH_AT, KIND_ECHO);
      push(CH_CR, KIND_ECHO);
      push(CH_LF, KIND_ECHO);
      kills++;
    endfunction

    // Returns the number of results this byte causes.
    function int take_byte(logic [7:0] b);
      logic [6:0] c;
      int first;
      result_t tail;
      c = b[6:0];
      first = pending_chars.size();
      case (c)
        CH_SPACE, CH_LF, CH_TAB: ;
        CH_BS: begin
          if (line_chars.size() > 0) begin
            void'(line_chars.pop_back());
            push(CH_BS, KIND_ECHO);
            push(CH_SPACE, KIND_ECHO);
            push(CH_BS, KIND_ECHO);
          end
        end
        CH_CR: begin
          push(CH_CR, KIND_ECHO);
          push(CH_LF, KIND_ECHO);
          if (line_chars.size() > 0) begin
            foreach (line_chars[i]) push(line_chars[i], KIND_LINE);
            line_chars.delete();
            lines_read++;
          end
        end
        default: begin
          if (c != CH_KILL && line_chars.size() < capacity) begin
            push(c, KIND_ECHO);
            line_chars.push_back(c);
          end else if (line_chars.size() > 0) begin
            if (c != CH_KILL) full_kills++;
            kill_line();
          end
        end
      endcase
      // flag the final result of this byte
      if (pending_chars.size() > first) begin
        tail = pending_chars.pop_back();
        tail.last = 1'b1;
        pending_chars.push_back(tail);
      end
      return pending_chars.size() - first;
    endfunction

    function void match_output(result_t got);
      result_t want;
      checked++;
      if (pending_chars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result char=%02h kind=%0d last=%0d",
                   $realtime, got.out_char, got.kind, got.last);
        return;
      end
      want = pending_chars.pop_front();
      if (got.out_char !== want.out_char || got.kind !== want.kind ||
          got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch char=%02h/%02h kind=%0d/%0d last=%0d/%0d (got/exp)",
                   $realtime, got.out_char, want.out_char, got.kind, want.kind,
                   got.last, want.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  lne_in_if in_ch();
  lne_out_if out_ch();

  echo_line_tracker tracker = new(LINE_LEN - 1);
  bit steady = 0;
  int bytes_sent = 0;
  int busy_items = 0;
  int stall_left = 0;

  logic [7:0] directed_bytes[] = '{
    8'h08, 8'h15, 8'h0D, 8'h20, 8'h09, 8'h0A, 8'hA0, 8'h00, 8'h7F, 8'hFF, 8'hC1,
    8'h08, 8'h88, 8'h0D, 8'h41, 8'h42, 8'h95, 8'h01, 8'h8D, 8'h40, 8'h0D
  };

  line_editor_with_echo #(.LINE_LEN(LINE_LEN)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_in <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (tracker.take_byte(b) > 0) busy_items++;
  endtask

  // Type a line of random content, with some editing mixed in, then hit return.
  task automatic send_line(input int len);
    logic [7:0] b;
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) b = {1'b0, CH_BS};
      else if (pick < 10) b = {1'b0, CH_KILL};
      else if (pick < 12) b = {1'b0, CH_SPACE};
      else if (pick < 13) b = {1'b0, CH_TAB};
      else if (pick < 14) b = {1'b0, CH_LF};
      else b = 8'($urandom_range(33, 126));
      b[7] = 1'($urandom_range(0, 1));
      send_byte(b);
    end
    b = {1'($urandom_range(0, 1)), CH_CR};
    send_byte(b);
  endtask

  // Output side: check each transaction and stall in random bursts.
  initial begin
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.out_char = out_ch.out_char;
        got.kind = out_ch.kind;
        got.last = out_ch.last;
        tracker.match_output(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ch.ready <= 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int seq;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.char_in <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    busy_items = 0;
    seq = 0;
    while (busy_items < RANDOM_ITEMS) begin
      if (busy_items >= STEADY_FROM) steady = 1;
      // open with a line of LINE_LEN - 1 to LINE_LEN + 4 bytes, which can overflow the store
      if (seq == 0) send_line($urandom_range(LINE_LEN - 1, LINE_LEN + 4));
      else if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
      else if ($urandom_range(0, 9) == 0) send_line($urandom_range(LINE_LEN - 3, LINE_LEN + 4));
      else send_line($urandom_range(0, 12));
      seq++;
    end
    in_ch.valid <= 1'b0;

    while (tracker.pending_chars.size() != 0) @(posedge clk);
    // catch any stray results after the last expected one
    repeat (2 * LINE_LEN + 8) @(posedge clk);

    $display("summary: %0d bytes typed, %0d results checked, %0d errors",
             bytes_sent, tracker.checked, tracker.errors);
    $display("summary: %0d lines read out, %0d kills (%0d from a full store)",
             tracker.lines_read, tracker.kills, tracker.full_kills);
    if (tracker.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/lne_pkg.sv
hdl/lne_in_if.sv
hdl/lne_out_if.sv
hdl/lne_store.sv
hdl/lne_out_reg.sv
hdl/line_editor_with_echo.sv
tb/tb.sv
